/* rtl/core/xeu_pkg.sv */
// Shared constants, tables and types of the XML entity unescape core.
// Depends on nothing; the front end, queue, back end and top level import it.
package xeu_pkg;

    typedef logic [7:0] t_byte;

    // Defaults for the candidate buffer length and the queue depth.
    localparam int ENTITY_MAX_LEN_DEF = 6;
    localparam int QUEUE_DEPTH_DEF    = 2;

    // Entity table: lt, gt, amp, quot, apos, in enable-bit order.
    localparam int NUM_ENT      = 5;
    localparam int ENT_TEXT_LEN = 6;
    localparam int ENABLE_W     = 5;

    localparam logic [ENABLE_W-1:0] ENABLE_RESET = 5'b11111;

    localparam t_byte CHAR_AMP = 8'h26;

    localparam t_byte ENT_TEXT [NUM_ENT][ENT_TEXT_LEN] = '{
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}   // &apos;
    };

    localparam int ENT_LEN [NUM_ENT] = '{4, 4, 5, 6, 6};

    localparam t_byte ENT_CHAR [NUM_ENT] = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27};

    // Status of the request queue between front and back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/core/xeu_ifs.sv */
// Valid/ready channel interfaces of the XML entity unescape core:
// input text, output text and the enable register write channel.
interface xeu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;
    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface xeu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_string_end;
    modport source (output valid, output out_byte, output out_last,
                    output out_string_end, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input out_string_end, output ready);
endinterface

interface xeu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] entity_enable;
    modport source (output valid, output entity_enable, input ready);
    modport sink   (input valid, input entity_enable, output ready);
endinterface

/* rtl/core/xeu_front.sv */
// Front end: accepts text bytes, tracks the pending candidate entity and
// turns each byte into at most one emit job. Depends on xeu_pkg and xeu_ifs.
module xeu_front #(
    parameter int ENTITY_MAX_LEN = xeu_pkg::ENTITY_MAX_LEN_DEF,
    localparam int CNT_W = $clog2(ENTITY_MAX_LEN + 1),
    localparam int JOB_W = ENTITY_MAX_LEN * 8 + CNT_W + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    xeu_in_if.sink                i_in,
    xeu_cfg_if.sink               i_cfg,
    input  xeu_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job
);
    import xeu_pkg::*;

    typedef struct packed {
        logic [ENTITY_MAX_LEN-1:0][7:0] bytes;
        logic [CNT_W-1:0]               count;
        logic                           str_end;
    } t_job;

    logic [ENABLE_W-1:0] r_enable;
    t_byte               r_held [ENTITY_MAX_LEN-1];
    logic [CNT_W-1:0]    r_cnt;

    t_byte               w [ENTITY_MAX_LEN];
    logic [CNT_W-1:0]    n_len;
    logic [CNT_W-1:0]    n_cnt;
    logic                full_hit;
    logic                prefix_hit;
    t_byte               dec_char;
    logic                push_job;
    logic                held_append;
    logic                held_amp;
    logic                accept;
    t_job                job;

    assign i_in.ready  = !i_q_stat.full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    // Candidate bytes followed by the new byte.
    always_comb begin
        for (int i = 0; i < ENTITY_MAX_LEN - 1; i++) begin
            w[i] = (CNT_W'(i) < r_cnt) ? r_held[i] : i_in.in_byte;
        end
        w[ENTITY_MAX_LEN-1] = i_in.in_byte;
        n_len = r_cnt + CNT_W'(1);
    end

    // Compare the candidate against every enabled entity.
    always_comb begin
        logic v_eq;
        full_hit   = 1'b0;
        prefix_hit = 1'b0;
        dec_char   = '0;
        for (int e = 0; e < NUM_ENT; e++) begin
            v_eq = 1'b1;
            for (int t = 0; t < ENT_TEXT_LEN; t++) begin
                if (t < ENT_LEN[e] && CNT_W'(t) < n_len && w[t] != ENT_TEXT[e][t]) begin
                    v_eq = 1'b0;
                end
            end
            if (r_enable[e] && v_eq) begin
                if (n_len == CNT_W'(ENT_LEN[e])) begin
                    if (!full_hit) begin
                        dec_char = ENT_CHAR[e];
                    end
                    full_hit = 1'b1;
                end else if (n_len < CNT_W'(ENT_LEN[e])) begin
                    prefix_hit = 1'b1;
                end
            end
        end
    end

    // Classify the byte into an emit job and the next candidate.
    always_comb begin
        for (int i = 0; i < ENTITY_MAX_LEN; i++) begin
            job.bytes[i] = w[i];
        end
        job.count   = n_len;
        job.str_end = i_in.in_end;
        push_job    = 1'b1;
        held_append = 1'b0;
        held_amp    = 1'b0;
        n_cnt       = '0;
        if (full_hit) begin
            job.bytes[0] = dec_char;
            job.count    = CNT_W'(1);
        end else if (prefix_hit && !i_in.in_end) begin
            push_job    = 1'b0;
            held_append = 1'b1;
            n_cnt       = n_len;
        end else if (!i_in.in_end && r_cnt != '0 && i_in.in_byte == CHAR_AMP
                     && (|r_enable)) begin
            // The old candidate failed; a new ampersand opens the next one.
            job.count = r_cnt;
            held_amp  = 1'b1;
            n_cnt     = CNT_W'(1);
        end
    end

    assign o_push = accept && push_job;
    assign o_job  = JOB_W'(job);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_enable <= ENABLE_RESET;
        end else begin
            if (accept) begin
                r_cnt <= n_cnt;
            end
            if (i_cfg.valid) begin
                r_enable <= i_cfg.entity_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < ENTITY_MAX_LEN - 1; i++) begin
                if (held_amp && i == 0) begin
                    r_held[i] <= CHAR_AMP;
                end else if (held_append && CNT_W'(i) == r_cnt) begin
                    r_held[i] <= i_in.in_byte;
                end
            end
        end
    end

endmodule

/* rtl/core/xeu_fifo.sv */
// Short request queue between the front and back end of the core.
// Depends on xeu_pkg for the status struct.
module xeu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = xeu_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output xeu_pkg::t_q_stat  o_stat
);
    import xeu_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CW-1:0]    r_count;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/xeu_back.sv */
// Back end: sends the bytes of each queued emit job one per cycle while
// ready, with last and end-of-string flags. Depends on xeu_pkg, xeu_ifs.
module xeu_back #(
    parameter int ENTITY_MAX_LEN = xeu_pkg::ENTITY_MAX_LEN_DEF,
    localparam int CNT_W = $clog2(ENTITY_MAX_LEN + 1),
    localparam int BI_W  = $clog2(ENTITY_MAX_LEN),
    localparam int JOB_W = ENTITY_MAX_LEN * 8 + CNT_W + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xeu_pkg::t_q_stat  i_q_stat,
    input  logic [JOB_W-1:0]  i_job,
    output logic              o_pop,
    xeu_out_if.source         o_out
);
    import xeu_pkg::*;

    typedef struct packed {
        logic [ENTITY_MAX_LEN-1:0][7:0] bytes;
        logic [CNT_W-1:0]               count;
        logic                           str_end;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EMIT = 2'b10
    } t_bk_state;

    t_bk_state        r_state;
    t_job             r_job;
    logic [CNT_W-1:0] r_idx;
    logic             last_byte;
    logic             load;

    assign last_byte = (r_idx == r_job.count - CNT_W'(1));
    assign load      = !i_q_stat.empty
                       && (r_state == BK_IDLE || (o_out.ready && last_byte));
    assign o_pop     = load;

    assign o_out.valid          = (r_state == BK_EMIT);
    assign o_out.out_byte       = r_job.bytes[r_idx[BI_W-1:0]];
    assign o_out.out_last       = last_byte;
    assign o_out.out_string_end = last_byte && r_job.str_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                BK_IDLE: begin
                    if (load) begin
                        r_idx   <= '0;
                        r_state <= BK_EMIT;
                    end
                end
                BK_EMIT: begin
                    if (o_out.ready) begin
                        if (last_byte) begin
                            r_idx <= '0;
                            if (!load) begin
                                r_state <= BK_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= t_job'(i_job);
        end
    end

endmodule

/* rtl/core/xml_entity_unescape_core.sv */
// Top level of the XML entity unescape core: front end, request queue and
// back end. Depends on xeu_pkg, xeu_ifs, xeu_front, xeu_fifo and xeu_back.
//
// Usage: escaped text enters on i_in one byte per request, with in_end set
// on the last byte of a string. Unescaped text leaves on o_out, one byte per
// request; out_last marks the last byte caused by an input byte and
// out_string_end the final byte of a string. The five-bit enable register
// (lt, gt, amp, quot, apos) is written on i_cfg; the user must write it only
// while the core is idle, which the core itself does not enforce.
// An accepted input byte passes through the queue and the back end's
// job register before its first result appears. Plain text flows at one
// byte per cycle while the receiver is ready; a byte that flushes a
// failed candidate limits the rate with up to six results, one per cycle.
// The queue between front and back lets the front keep accepting while the
// back end is busy, until the queue is full; then i_in.ready drops.
// When the receiver stalls, o_out holds its byte and flags unchanged.
// Reset empties the candidate buffer and the queue and enables all five
// entities.
module xml_entity_unescape_core #(
    parameter int ENTITY_MAX_LEN = xeu_pkg::ENTITY_MAX_LEN_DEF,
    parameter int QUEUE_DEPTH    = xeu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xeu_in_if.sink     i_in,
    xeu_cfg_if.sink    i_cfg,
    xeu_out_if.source  o_out
);
    import xeu_pkg::*;

    // Each emit job carries the candidate bytes, how many to send and the
    // end-of-string flag.
    localparam int CNT_W = $clog2(ENTITY_MAX_LEN + 1);
    localparam int JOB_W = ENTITY_MAX_LEN * 8 + CNT_W + 1;

    t_q_stat          q_stat;
    logic             push;
    logic             pop;
    logic [JOB_W-1:0] push_job;
    logic [JOB_W-1:0] head_job;

    // The front end decides, per input byte, what must be sent and what
    // stays pending as a candidate entity.
    xeu_front #(
        .ENTITY_MAX_LEN (ENTITY_MAX_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    xeu_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (q_stat)
    );

    // The back end serializes each job onto the output channel.
    xeu_back #(
        .ENTITY_MAX_LEN (ENTITY_MAX_LEN)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

/* rtl/core/xeu_checker.sv */
// Port-level checks of the XML entity unescape core and the bind that
// attaches them to the top level. Depends on xml_entity_unescape_core.
module xeu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_string_end
);

    // A stalled result keeps its byte and flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last) && $stable(i_out_string_end))
        else $error("stalled output changed");

    // Reset leaves no result on the output.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The end of a string is always the last result of its input byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_string_end |-> i_out_last)
        else $error("string end without last");

    // A run of results from one input byte is sent without gaps.
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a result run");

endmodule

bind xml_entity_unescape_core xeu_checker u_xeu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_last       (o_out.out_last),
    .i_out_string_end (o_out.out_string_end)
);
